### src/sfd_pkg.sv
// Shared types and constants for the stereo feedback delay.
// No dependencies; the other files that use it refer to it by scoped names.
package sfd_pkg;

	localparam int DELAY_W = 16;
	localparam int GAIN_W  = 17;
	localparam int LEN_W   = 13;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 17;
	// settings are kept as signed Q.32 / Q16.16 values
	localparam int RAMP_W  = 35;
	localparam int DIV_W   = 34;
	localparam int GAIN_OW = 33;

	localparam logic [GAIN_W-1:0]  GAIN_ONE     = 17'd65536;
	localparam logic [DELAY_W-1:0] DELAY_RESET  = 16'd4800;
	localparam logic [GAIN_W-1:0]  FB_RESET     = 17'd0;
	localparam logic [GAIN_W-1:0]  MIX_RESET    = 17'd0;
	localparam logic [LEN_W-1:0]   RAMP_RESET   = 13'd480;

	typedef enum logic [CFG_IW-1:0] {
		REG_DELAY    = 2'd0,
		REG_FEEDBACK = 2'd1,
		REG_MIX      = 2'd2,
		REG_RAMP     = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic rd;
		logic mul;
		logic fin;
		logic clr;
	} lane_ctrl_t;

	function automatic logic signed [RAMP_W-1:0] delay_target(input logic [DELAY_W-1:0] v);
		return $signed({3'b000, v, 16'h0000});
	endfunction

	function automatic logic signed [RAMP_W-1:0] gain_target(input logic [GAIN_W-1:0] v);
		logic [GAIN_W-1:0] c;
		c = (v > GAIN_ONE) ? GAIN_ONE : v;
		return $signed({2'b00, c, 16'h0000});
	endfunction

endpackage

### src/sfd_in_if.sv
// Input request channel: one stereo sample pair.
// Depends on nothing; width follows the SB parameter.
interface sfd_in_if #(parameter int SB = 16);
	logic          valid;
	logic          ready;
	logic [SB-1:0] in_left;
	logic [SB-1:0] in_right;
	modport source (output valid, in_left, in_right, input ready);
	modport sink   (input valid, in_left, in_right, output ready);
endinterface

### src/sfd_out_if.sv
// Output request channel: one mixed stereo sample pair.
// Depends on nothing; width follows the SB parameter.
interface sfd_out_if #(parameter int SB = 16);
	logic          valid;
	logic          ready;
	logic [SB-1:0] out_left;
	logic [SB-1:0] out_right;
	modport source (output valid, out_left, out_right, input ready);
	modport sink   (input valid, out_left, out_right, output ready);
endinterface

### src/sfd_div.sv
// Restoring divider, one quotient bit per cycle, signed result.
// Depends on sfd_pkg.
module sfd_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              neg,
	input  logic [sfd_pkg::DIV_W-1:0]         dividend,
	input  logic [sfd_pkg::LEN_W-1:0]         divisor,
	output logic                              busy,
	output logic                              done,
	output logic signed [sfd_pkg::RAMP_W-1:0] quotient
);
	localparam int CW = $clog2(sfd_pkg::DIV_W);

	logic [sfd_pkg::LEN_W-1:0] rem_q;
	logic [sfd_pkg::LEN_W-1:0] div_q;
	logic [sfd_pkg::DIV_W-1:0] quo_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q, done_q, neg_q;
	logic [sfd_pkg::LEN_W:0]   trial;
	logic                      fits;

	assign trial = {rem_q, quo_q[sfd_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(sfd_pkg::DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= fits ? sfd_pkg::LEN_W'(trial - {1'b0, div_q})
			              : trial[sfd_pkg::LEN_W-1:0];
			quo_q <= {quo_q[sfd_pkg::DIV_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

### src/sfd_ramp.sv
// Linear glide of one setting toward its target, with step division.
// Depends on sfd_pkg and sfd_div.
module sfd_ramp #(
	parameter logic signed [sfd_pkg::RAMP_W-1:0] RESET_NOW = '0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              aim,
	input  logic signed [sfd_pkg::RAMP_W-1:0] aim_target,
	input  logic [sfd_pkg::LEN_W-1:0]         ramp_len,
	input  logic                              advance,
	input  logic signed [sfd_pkg::RAMP_W-1:0] target,
	output logic signed [sfd_pkg::RAMP_W-1:0] now,
	output logic                              busy
);
	logic signed [sfd_pkg::RAMP_W-1:0] now_q, step_q, diff, quo;
	logic [sfd_pkg::LEN_W-1:0]         left_q;
	logic                              div_start, div_busy, div_done;
	logic [sfd_pkg::DIV_W-1:0]         mag;

	assign diff      = aim_target - now_q;
	assign mag       = diff[sfd_pkg::RAMP_W-1] ? sfd_pkg::DIV_W'(-diff)
	                                            : sfd_pkg::DIV_W'(diff);
	assign div_start = aim && (ramp_len != '0);

	sfd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.neg      (diff[sfd_pkg::RAMP_W-1]),
		.dividend (mag),
		.divisor  (ramp_len),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q  <= RESET_NOW;
			step_q <= '0;
			left_q <= '0;
		end else if (aim) begin
			if (ramp_len == '0) begin
				now_q  <= aim_target;
				step_q <= '0;
				left_q <= '0;
			end else begin
				left_q <= ramp_len;
			end
		end else if (div_done) begin
			step_q <= quo;
		end else if (advance) begin
			if (left_q == '0) begin
				now_q <= target;
			end else begin
				left_q <= left_q - 1'b1;
				now_q  <= (left_q != sfd_pkg::LEN_W'(1)) ? now_q + step_q : target;
			end
		end
	end

	assign now  = now_q;
	assign busy = div_busy | div_done;
endmodule

### src/sfd_lane.sv
// One channel of the delay: sample line memory, gain products, rounding.
// Depends on sfd_pkg.
module sfd_lane #(
	parameter int LINE_DEPTH  = 65536,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  sfd_pkg::lane_ctrl_t                ctrl,
	input  logic [$clog2(LINE_DEPTH)-1:0]      rd_addr,
	input  logic [$clog2(LINE_DEPTH)-1:0]      wr_addr,
	input  logic signed [SAMPLE_BITS-1:0]      x,
	input  logic [sfd_pkg::GAIN_OW-1:0]        mix,
	input  logic [sfd_pkg::GAIN_OW-1:0]        fb,
	output logic signed [SAMPLE_BITS-1:0]      y
);
	localparam int MW = SAMPLE_BITS + sfd_pkg::GAIN_OW + 1;
	localparam int PW = SAMPLE_BITS + 36;
	localparam int QW = PW - 32;
	localparam logic signed [QW-1:0] HI = QW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [QW-1:0] LO = -HI - 1;

	logic [SAMPLE_BITS-1:0]        mem [LINE_DEPTH];
	logic signed [SAMPLE_BITS-1:0] d_q, y_q, st;
	logic signed [MW-1:0]          pdry_s2, pmix_s2, pfb_s2;
	logic [sfd_pkg::GAIN_OW-1:0]   dry;

	function automatic logic signed [SAMPLE_BITS-1:0] rsat(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] t;
		logic signed [QW-1:0] q;
		t = v + $signed({{(PW-32){1'b0}}, 1'b1, 31'd0});
		q = t[PW-1:32];
		if (q > HI) q = HI;
		if (q < LO) q = LO;
		return q[SAMPLE_BITS-1:0];
	endfunction

	assign dry = sfd_pkg::GAIN_OW'(34'h1_0000_0000 - {1'b0, mix});
	assign st  = rsat(PW'($signed({x, 32'd0})) + PW'(pfb_s2));

	always_ff @(posedge clk) begin
		if (ctrl.rd) d_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.clr) mem[wr_addr] <= '0;
		else if (ctrl.fin) mem[wr_addr] <= st;
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			pdry_s2 <= x * $signed({1'b0, dry});
			pmix_s2 <= d_q * $signed({1'b0, mix});
			pfb_s2  <= d_q * $signed({1'b0, fb});
		end
		if (ctrl.fin) y_q <= rsat(PW'(pdry_s2) + PW'(pmix_s2));
	end

	assign y = y_q;
endmodule

### src/stereo_feedback_delay.sv
// Stereo feedback delay: top level, control sequencer and setting glides.
// Depends on sfd_pkg, sfd_in_if, sfd_out_if, sfd_ramp and sfd_lane.
//
// One stereo pair in gives one mixed pair out. Each item runs through the
// steps line read, gain multiply, round and store, and output load after it
// is accepted. A new pair is taken only once the previous output load is
// done, which waits for a free output register; that register may still hold
// the previous result when the next pair is taken. After reset the two sample
// lines are cleared one address per cycle, and no pair is taken until that
// pass ends; register writes are taken the whole time. A write that changes
// the delay, feedback or mix target with a nonzero ramp length starts a step
// division for that glide and then loads the step; no pair is taken meanwhile.
// Both channels run as identical lanes side by side and share the address,
// gain and control sequencing; their results are merged into one request.
module stereo_feedback_delay #(
	parameter int LINE_DEPTH  = 65536,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [sfd_pkg::CFG_IW-1:0]     wr_index,
	input  logic [sfd_pkg::CFG_DW-1:0]     wr_data,
	sfd_in_if.sink                         sample_in,
	sfd_out_if.source                      sample_out
);
	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = (AW + 1 > 17) ? AW + 1 : 17;
	localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);
	localparam int RW = sfd_pkg::RAMP_W;

	typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_MUL, ST_FIN, ST_OUT} state_t;
	state_t state_q;

	// configuration targets as written
	logic [sfd_pkg::DELAY_W-1:0] delay_q;
	logic [sfd_pkg::GAIN_W-1:0]  fb_q, mix_q;
	logic [sfd_pkg::LEN_W-1:0]   len_q;

	logic aim_delay, aim_fb, aim_mix;
	logic signed [RW-1:0] new_delay_t, new_fb_t, new_mix_t;
	logic signed [RW-1:0] delay_now, fb_now, mix_now;
	logic busy_delay, busy_fb, busy_mix;

	logic clr_q;
	logic [AW-1:0] clr_addr_q, wp_q, rd_addr, wr_addr;
	logic [CW-1:0] d_ext, d_clip, wp_ext, rd_full;

	logic signed [SAMPLE_BITS-1:0] xl_q, xr_q, yl, yr;
	logic                          out_valid_q;
	logic [SAMPLE_BITS-1:0]        out_l_q, out_r_q;
	logic                          accept, out_free;
	sfd_pkg::lane_ctrl_t           ctrl;

	// Decode a register write; a glide restarts only on a real target change.
	assign new_delay_t = sfd_pkg::delay_target(wr_data[sfd_pkg::DELAY_W-1:0]);
	assign new_fb_t    = sfd_pkg::gain_target(wr_data);
	assign new_mix_t   = sfd_pkg::gain_target(wr_data);
	assign aim_delay = wr_en && (wr_index == sfd_pkg::REG_DELAY)
	                   && (new_delay_t != sfd_pkg::delay_target(delay_q));
	assign aim_fb    = wr_en && (wr_index == sfd_pkg::REG_FEEDBACK)
	                   && (new_fb_t != sfd_pkg::gain_target(fb_q));
	assign aim_mix   = wr_en && (wr_index == sfd_pkg::REG_MIX)
	                   && (new_mix_t != sfd_pkg::gain_target(mix_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= sfd_pkg::DELAY_RESET;
			fb_q    <= sfd_pkg::FB_RESET;
			mix_q   <= sfd_pkg::MIX_RESET;
			len_q   <= sfd_pkg::RAMP_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				sfd_pkg::REG_DELAY:    delay_q <= wr_data[sfd_pkg::DELAY_W-1:0];
				sfd_pkg::REG_FEEDBACK: fb_q    <= wr_data;
				sfd_pkg::REG_MIX:      mix_q   <= wr_data;
				sfd_pkg::REG_RAMP:     len_q   <= wr_data[sfd_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Glides advance on every accepted pair, before it is processed, but not in a cycle that aims them.
	sfd_ramp #(.RESET_NOW(sfd_pkg::delay_target(sfd_pkg::DELAY_RESET))) u_ramp_delay (
		.clk(clk), .arst_n(arst_n), .aim(aim_delay), .aim_target(new_delay_t),
		.ramp_len(len_q), .advance(accept), .target(sfd_pkg::delay_target(delay_q)),
		.now(delay_now), .busy(busy_delay)
	);
	sfd_ramp #(.RESET_NOW(sfd_pkg::gain_target(sfd_pkg::FB_RESET))) u_ramp_fb (
		.clk(clk), .arst_n(arst_n), .aim(aim_fb), .aim_target(new_fb_t),
		.ramp_len(len_q), .advance(accept), .target(sfd_pkg::gain_target(fb_q)),
		.now(fb_now), .busy(busy_fb)
	);
	sfd_ramp #(.RESET_NOW(sfd_pkg::gain_target(sfd_pkg::MIX_RESET))) u_ramp_mix (
		.clk(clk), .arst_n(arst_n), .aim(aim_mix), .aim_target(new_mix_t),
		.ramp_len(len_q), .advance(accept), .target(sfd_pkg::gain_target(mix_q)),
		.now(mix_now), .busy(busy_mix)
	);

	// Read address: write position minus the whole-sample delay, with wrap.
	// A delay of zero or beyond the line reads a full line back.
	assign d_ext   = CW'(delay_now[31:16]);
	assign d_clip  = (d_ext > DEPTH_C) ? DEPTH_C : d_ext;
	assign wp_ext  = CW'(wp_q);
	assign rd_full = (wp_ext >= d_clip) ? wp_ext - d_clip : wp_ext + DEPTH_C - d_clip;
	assign rd_addr = rd_full[AW-1:0];
	assign wr_addr = clr_q ? clr_addr_q : wp_q;

	assign sample_in.ready = (state_q == ST_IDLE) && !clr_q
	                         && !busy_delay && !busy_fb && !busy_mix;
	assign accept   = sample_in.valid && sample_in.ready;
	assign out_free = !out_valid_q || sample_out.ready;

	always_comb begin
		ctrl.rd  = (state_q == ST_RD);
		ctrl.mul = (state_q == ST_MUL);
		ctrl.fin = (state_q == ST_FIN);
		ctrl.clr = clr_q;
	end

	sfd_lane #(.LINE_DEPTH(LINE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
		.clk(clk), .ctrl(ctrl), .rd_addr(rd_addr), .wr_addr(wr_addr), .x(xl_q),
		.mix(mix_now[sfd_pkg::GAIN_OW-1:0]), .fb(fb_now[sfd_pkg::GAIN_OW-1:0]), .y(yl)
	);
	sfd_lane #(.LINE_DEPTH(LINE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
		.clk(clk), .ctrl(ctrl), .rd_addr(rd_addr), .wr_addr(wr_addr), .x(xr_q),
		.mix(mix_now[sfd_pkg::GAIN_OW-1:0]), .fb(fb_now[sfd_pkg::GAIN_OW-1:0]), .y(yr)
	);

	// Sequencer: clear pass after reset, then read, multiply, store, output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(LINE_DEPTH - 1)) clr_q <= 1'b0;
			end
			// drop a taken result unless a new one loads this cycle
			if (sample_out.ready && (state_q != ST_OUT)) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_RD;
				ST_RD:   state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_FIN;
				ST_FIN: begin
					// advance the write position once the pair is stored
					wp_q    <= (wp_q == AW'(LINE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold until the output register frees up
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xl_q <= $signed(sample_in.in_left);
			xr_q <= $signed(sample_in.in_right);
		end
		if ((state_q == ST_OUT) && out_free) begin
			out_l_q <= yl;
			out_r_q <= yr;
		end
	end

	assign sample_out.valid     = out_valid_q;
	assign sample_out.out_left  = out_l_q;
	assign sample_out.out_right = out_r_q;
endmodule
